### rtl/ssd_pkg.sv
// Shared types, constants and helper functions of the seven-segment serial display driver.
package ssd_pkg;

  // Input command codes as they arrive on the request channel.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NUM  = 2'd1;
  localparam logic [1:0] CMD_VOLT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_CMD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDR_CMD = 1'd1;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] DATA_CMD_RESET = 8'h40;
  localparam logic [7:0] ADDR_CMD_RESET = 8'hC0;

  // Queue depth default for the item and result queues.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Frame layout.
  localparam int FRAME_LEN  = 7;
  localparam int BYTE_IDX_W = 3;

  // Binary to BCD converter sizing.
  localparam int BIN_W      = 17;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BCD_CNT_W  = $clog2(BIN_W + 1);

  // Segment patterns beyond the digit table.
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_VOLT = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_BITS  = 3'd2,
    ST_ACK   = 3'd3,
    ST_STOP  = 3'd4
  } stage_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] value;
    logic [7:0]  brightness;
    logic        dio_in;
  } in_item_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic busy_res;
    logic nack_seen;
    logic frame_done;
  } res_item_t;

  // Classified item as it travels from the front to the sequencer.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic [7:0]  brightness;
    logic        dio_in;
  } item_t;

  // Converter status and digits, least significant digit at index 0.
  typedef struct packed {
    logic                         done;
    logic                         volt;
    logic [BCD_DIGITS-1:0][3:0]   digits;
  } bcd_result_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

### rtl/ssd_fifo.sv
// Small register queue used between the front and the sequencer and for results.
module ssd_fifo #(
  parameter int  DEPTH = ssd_pkg::QUEUE_DEPTH_DEFAULT,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/ssd_bcd.sv
// Shift-and-add-three binary to BCD converter, one input bit per cycle.
module ssd_bcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ssd_pkg::BIN_W-1:0]  operand,
  input  logic                       volt,
  output ssd_pkg::bcd_result_t       result
);

  logic [ssd_pkg::BIN_W-1:0]     shreg;
  logic [ssd_pkg::BCD_W-1:0]     bcd;
  logic [ssd_pkg::BCD_W-1:0]     bcd_adj;
  logic [ssd_pkg::BCD_CNT_W-1:0] count;
  logic                          running;
  logic                          done;
  logic                          volt_r;

  // Digits of five or more get three added before the shift.
  always_comb begin
    for (int i = 0; i < ssd_pkg::BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= ssd_pkg::BCD_CNT_W'(ssd_pkg::BIN_W);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == ssd_pkg::BCD_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg  <= operand;
      bcd    <= '0;
      volt_r <= volt;
    end else if (running) begin
      bcd   <= {bcd_adj[ssd_pkg::BCD_W-2:0], shreg[ssd_pkg::BIN_W-1]};
      shreg <= {shreg[ssd_pkg::BIN_W-2:0], 1'b0};
    end
  end

  assign result.done   = done;
  assign result.volt   = volt_r;
  assign result.digits = bcd;

endmodule

### rtl/ssd_seq.sv
// Bus sequencer: frame store, configuration registers and line edge generation.
module ssd_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              item_valid,
  input  ssd_pkg::item_t                    item,
  output logic                              take,
  input  logic                              res_full,
  output ssd_pkg::res_item_t                res
);

  localparam int IW = ssd_pkg::BYTE_IDX_W;
  localparam logic [IW-1:0] SLOT_DATA_CMD = IW'(0);
  localparam logic [IW-1:0] SLOT_ADDR_CMD = IW'(1);
  localparam logic [IW-1:0] SLOT_DIGIT0   = IW'(2);
  localparam logic [IW-1:0] SLOT_DIGIT1   = IW'(3);
  localparam logic [IW-1:0] SLOT_DIGIT2   = IW'(4);
  localparam logic [IW-1:0] SLOT_DIGIT3   = IW'(5);
  localparam logic [IW-1:0] SLOT_BRIGHT   = IW'(6);

  localparam logic [2:0] START_LAST = 3'd3;
  localparam logic [2:0] BIT_LAST   = 3'd2;
  localparam logic [2:0] ACK_SAMPLE = 3'd2;
  localparam logic [2:0] ACK_LAST   = 3'd4;
  localparam logic [2:0] STOP_LAST  = 3'd3;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  ssd_pkg::stage_t      stage, stage_next;
  logic [IW-1:0]        byte_index, byte_index_next;
  logic [3:0]           bit_index, bit_index_next;
  logic [2:0]           edge_phase, edge_phase_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic                 clock_level, clock_level_next;
  logic                 data_level, data_level_next;
  logic                 nack_flag, nack_flag_next;
  logic [7:0]           data_cmd, addr_cmd;
  logic [7:0]           frame_bytes [ssd_pkg::FRAME_LEN];

  logic                 busy, is_tick, is_req, frame_done;
  logic [IW-1:0]        next_idx;
  logic [7:0]           next_byte;
  logic [3:0]           bit_index_inc;
  logic                 last_of_txn;
  ssd_pkg::bcd_result_t cv;
  logic [ssd_pkg::BIN_W-1:0] cv_operand;

  assign take    = item_valid && !res_full;
  assign busy    = (stage != ssd_pkg::ST_IDLE);
  assign is_tick = take && busy && (item.kind == ssd_pkg::KIND_TICK);
  assign is_req  = take && !busy &&
                   (item.kind == ssd_pkg::KIND_NUM || item.kind == ssd_pkg::KIND_VOLT);

  assign next_idx      = byte_index + 1'b1;
  assign next_byte     = (next_idx < IW'(ssd_pkg::FRAME_LEN)) ? frame_bytes[next_idx] : 8'h00;
  assign bit_index_inc = bit_index + 4'd1;
  assign last_of_txn   = (byte_index == SLOT_DATA_CMD) || (byte_index >= SLOT_DIGIT3);

  // Voltage is rounded to the last shown digit by adding half a step before conversion.
  assign cv_operand = (item.kind == ssd_pkg::KIND_VOLT) ?
                      ({1'b0, item.value} + 17'd5) : {1'b0, item.value};

  ssd_bcd u_bcd (
    .clk     (clk),
    .rst     (rst),
    .start   (is_req),
    .operand (cv_operand),
    .volt    (item.kind == ssd_pkg::KIND_VOLT),
    .result  (cv)
  );

  // Next stage.
  always_comb begin
    stage_next = stage;
    if (is_req) begin
      stage_next = ssd_pkg::ST_START;
    end else if (is_tick) begin
      unique case (stage)
        ssd_pkg::ST_START: begin
          if (edge_phase >= START_LAST) stage_next = ssd_pkg::ST_BITS;
        end
        ssd_pkg::ST_BITS: begin
          if (edge_phase >= BIT_LAST && bit_index_inc >= BITS_PER_BYTE) begin
            stage_next = ssd_pkg::ST_ACK;
          end
        end
        ssd_pkg::ST_ACK: begin
          if (edge_phase >= ACK_LAST) begin
            stage_next = last_of_txn ? ssd_pkg::ST_STOP : ssd_pkg::ST_BITS;
          end
        end
        ssd_pkg::ST_STOP: begin
          if (edge_phase >= STOP_LAST) begin
            stage_next = (byte_index >= SLOT_BRIGHT) ? ssd_pkg::ST_IDLE : ssd_pkg::ST_START;
          end
        end
        default: stage_next = stage;
      endcase
    end
  end

  // Line levels, counters and the result of each item.
  always_comb begin
    byte_index_next  = byte_index;
    bit_index_next   = bit_index;
    edge_phase_next  = edge_phase;
    shift_byte_next  = shift_byte;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    nack_flag_next   = nack_flag;
    frame_done       = 1'b0;
    if (is_req) begin
      byte_index_next = '0;
      bit_index_next  = '0;
      edge_phase_next = '0;
      shift_byte_next = data_cmd;
      nack_flag_next  = 1'b0;
    end else if (is_tick) begin
      unique case (stage)
        ssd_pkg::ST_START: begin
          priority case (edge_phase)
            3'd0:    data_level_next  = 1'b1;
            3'd1:    clock_level_next = 1'b1;
            3'd2:    data_level_next  = 1'b0;
            default: clock_level_next = 1'b0;
          endcase
          if (edge_phase >= START_LAST) begin
            edge_phase_next = '0;
            bit_index_next  = '0;
          end else begin
            edge_phase_next = edge_phase + 3'd1;
          end
        end
        ssd_pkg::ST_BITS: begin
          priority case (edge_phase)
            3'd0: clock_level_next = 1'b0;
            3'd1: begin
              data_level_next = shift_byte[0];
              shift_byte_next = shift_byte >> 1;
            end
            default: clock_level_next = 1'b1;
          endcase
          if (edge_phase >= BIT_LAST) begin
            edge_phase_next = '0;
            bit_index_next  = bit_index_inc;
          end else begin
            edge_phase_next = edge_phase + 3'd1;
          end
        end
        ssd_pkg::ST_ACK: begin
          priority case (edge_phase)
            3'd0: clock_level_next = 1'b0;
            3'd1: data_level_next  = 1'b1;
            3'd2: begin
              clock_level_next = 1'b1;
              if (item.dio_in) nack_flag_next = 1'b1;
            end
            3'd3:    clock_level_next = 1'b0;
            default: data_level_next  = 1'b0;
          endcase
          if (edge_phase >= ACK_LAST) begin
            edge_phase_next = '0;
            if (!last_of_txn) begin
              byte_index_next = next_idx;
              shift_byte_next = next_byte;
              bit_index_next  = '0;
            end
          end else begin
            edge_phase_next = edge_phase + 3'd1;
          end
        end
        ssd_pkg::ST_STOP: begin
          priority case (edge_phase)
            3'd0:    clock_level_next = 1'b0;
            3'd1:    data_level_next  = 1'b0;
            3'd2:    clock_level_next = 1'b1;
            default: data_level_next  = 1'b1;
          endcase
          if (edge_phase >= STOP_LAST) begin
            edge_phase_next = '0;
            if (byte_index >= SLOT_BRIGHT) begin
              frame_done = 1'b1;
            end else begin
              byte_index_next = next_idx;
              shift_byte_next = next_byte;
              bit_index_next  = '0;
            end
          end else begin
            edge_phase_next = edge_phase + 3'd1;
          end
        end
        default: edge_phase_next = edge_phase;
      endcase
    end
    res.clk_out    = clock_level_next;
    res.dio_out    = data_level_next;
    res.busy_res   = (stage_next != ssd_pkg::ST_IDLE);
    res.nack_seen  = nack_flag_next;
    res.frame_done = frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ssd_pkg::ST_IDLE;
      byte_index  <= '0;
      bit_index   <= '0;
      edge_phase  <= '0;
      shift_byte  <= '0;
      clock_level <= 1'b1;
      data_level  <= 1'b1;
      nack_flag   <= 1'b0;
      data_cmd    <= ssd_pkg::DATA_CMD_RESET;
      addr_cmd    <= ssd_pkg::ADDR_CMD_RESET;
    end else begin
      if (take) begin
        stage       <= stage_next;
        byte_index  <= byte_index_next;
        bit_index   <= bit_index_next;
        edge_phase  <= edge_phase_next;
        shift_byte  <= shift_byte_next;
        clock_level <= clock_level_next;
        data_level  <= data_level_next;
        nack_flag   <= nack_flag_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ssd_pkg::REG_DATA_CMD: data_cmd <= cfg_data;
          ssd_pkg::REG_ADDR_CMD: addr_cmd <= cfg_data;
          default:               data_cmd <= data_cmd;
        endcase
      end
    end
  end

  // Command, address and brightness bytes land at the request; the digits
  // follow when the converter finishes, long before the bus reaches them.
  always_ff @(posedge clk) begin
    if (is_req) begin
      frame_bytes[SLOT_DATA_CMD] <= data_cmd;
      frame_bytes[SLOT_ADDR_CMD] <= addr_cmd;
      frame_bytes[SLOT_BRIGHT]   <= item.brightness;
    end
    if (cv.done) begin
      if (cv.volt) begin
        frame_bytes[SLOT_DIGIT0] <= ssd_pkg::seg_of(cv.digits[3]);
        frame_bytes[SLOT_DIGIT1] <= ssd_pkg::seg_of(cv.digits[2]) | ssd_pkg::SEG_DP;
        frame_bytes[SLOT_DIGIT2] <= ssd_pkg::seg_of(cv.digits[1]);
        frame_bytes[SLOT_DIGIT3] <= ssd_pkg::SEG_BLANK;
      end else begin
        frame_bytes[SLOT_DIGIT0] <= ssd_pkg::seg_of(cv.digits[3]);
        frame_bytes[SLOT_DIGIT1] <= ssd_pkg::seg_of(cv.digits[2]);
        frame_bytes[SLOT_DIGIT2] <= ssd_pkg::seg_of(cv.digits[1]);
        frame_bytes[SLOT_DIGIT3] <= ssd_pkg::seg_of(cv.digits[0]);
      end
    end
  end

`ifndef SYNTHESIS
  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    is_req |=> (stage == ssd_pkg::ST_START) && (edge_phase == '0))
    else $error("accepted request did not enter the start stage");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && frame_done) |=> (stage == ssd_pkg::ST_IDLE))
    else $error("frame done without returning to idle");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    (stage == ssd_pkg::ST_BITS) |-> (bit_index < BITS_PER_BYTE))
    else $error("bit counter ran past one byte");

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (byte_index <= SLOT_BRIGHT))
    else $error("byte index left the frame");
`endif

endmodule

### rtl/seven_segment_serial_display_driver.sv
// Top level of the seven-segment serial display driver.
//
// Usage: items enter through a queue-style port (push/full) and every item
// gives exactly one result on a queue-style port (empty/pop). A request item
// (show number or show voltage) captures a seven-byte frame while the bus is
// idle; requests made during a frame are ignored but still return a result.
// Each tick item during a frame moves the clock or data line by one edge and
// the result carries the new line levels, the busy flag, the sticky nack
// flag and the frame-done pulse. The two command bytes are set through
// cfg_we, cfg_index and cfg_data; the user must do so while the block is
// idle, which the block does not enforce. Throughput is one item per cycle
// while results are popped: the sequencer settles one item per cycle and
// the queues on both sides let a transfer happen in every cycle. An item
// passes the item queue and the result queue before its result shows.
// Digits come from a shift-and-add-three converter that runs in the
// background after a request and is done before the bus reaches the first
// digit byte. Reset (synchronous, rst high) empties both queues, releases
// both lines high, returns to idle and restores the command bytes 0x40 and
// 0xC0. When the receiver stops popping, results collect in the result
// queue, the sequencer then holds, and full rises once the item queue fills.
module seven_segment_serial_display_driver #(
  parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  ssd_pkg::in_item_t                req,
  output logic                             full,
  output logic                             empty,
  input  logic                             pop,
  output ssd_pkg::res_item_t               res,
  input  logic                             cfg_we,
  input  logic [ssd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ssd_pkg::item_t     front_item;
  ssd_pkg::item_t     seq_item;
  ssd_pkg::res_item_t seq_res;
  logic               item_empty;
  logic               take;
  logic               res_full;

  // Front: classify the command so the sequencer only sees kinds of work.
  always_comb begin
    front_item.value      = req.value;
    front_item.brightness = req.brightness;
    front_item.dio_in     = req.dio_in;
    unique case (req.cmd)
      ssd_pkg::CMD_TICK: front_item.kind = ssd_pkg::KIND_TICK;
      ssd_pkg::CMD_NUM:  front_item.kind = ssd_pkg::KIND_NUM;
      ssd_pkg::CMD_VOLT: front_item.kind = ssd_pkg::KIND_VOLT;
      default:           front_item.kind = ssd_pkg::KIND_NONE;
    endcase
  end

  ssd_fifo #(
    .DEPTH   (QUEUE_DEPTH),
    .entry_t (ssd_pkg::item_t)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (take),
    .rdata (seq_item),
    .empty (item_empty)
  );

  ssd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!item_empty),
    .item       (seq_item),
    .take       (take),
    .res_full   (res_full),
    .res        (seq_res)
  );

  ssd_fifo #(
    .DEPTH   (QUEUE_DEPTH),
    .entry_t (ssd_pkg::res_item_t)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (seq_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res),
    .empty (empty)
  );

endmodule
